[rtl/seiq_pkg.sv]
// Package for the sorted event insertion queue.
// Holds the queue depth, the field widths, the function and status codes and the item types.
// No dependencies.
package seiq_pkg;

    localparam int DEPTH   = 16;
    localparam int IDX_W   = $clog2(DEPTH);
    localparam int OCC_W   = $clog2(DEPTH + 1);
    localparam int CAP_W   = 5;
    localparam int COUNT_W = 5;

    typedef enum logic [2:0] {
        FUNC_PUSH  = 3'd0,
        FUNC_POP   = 3'd1,
        FUNC_FLUSH = 3'd2,
        FUNC_ABORT = 3'd3,
        FUNC_RESET = 3'd4
    } t_func;

    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_REFUSED = 2'd1;
    localparam logic [1:0] STAT_ABORTED = 2'd2;

    typedef enum logic {
        CTL_IDLE,
        CTL_EXEC
    } t_ctl_state;

    typedef struct packed {
        logic [2:0]         func;
        logic [15:0]        in_serial;
        logic signed [47:0] in_time;
        logic [15:0]        in_payload;
    } t_in_item;

    typedef struct packed {
        logic [1:0]          status;
        logic [15:0]         out_serial;
        logic signed [47:0]  out_time;
        logic [15:0]         out_payload;
        logic [COUNT_W-1:0]  count;
    } t_out_item;

    typedef struct packed {
        logic load;
        logic exec;
    } t_dp_cmd;

    typedef struct packed {
        logic aborted;
        logic empty;
    } t_dp_sts;

endpackage

[rtl/seiq_ctrl.sv]
// Controller of the sorted event insertion queue.
// Runs the handshakes and issues load and execute commands to the datapath.
// Depends on seiq_pkg.
module seiq_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output seiq_pkg::t_dp_cmd   o_cmd,
    input  seiq_pkg::t_dp_sts   i_sts
);

    seiq_pkg::t_ctl_state r_state;
    seiq_pkg::t_ctl_state n_state;
    logic                 r_out_valid;
    logic                 n_out_valid;
    logic                 accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= seiq_pkg::CTL_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && i_out_stall;
        o_in_stall  = 1'b1;
        accept      = 1'b0;
        o_cmd       = '0;
        unique case (r_state)
            seiq_pkg::CTL_IDLE: begin
                o_in_stall = r_out_valid && i_out_stall;
                accept     = i_in_valid && !o_in_stall;
                o_cmd.load = accept;
                if (accept) begin
                    n_state = seiq_pkg::CTL_EXEC;
                end
            end
            seiq_pkg::CTL_EXEC: begin
                o_cmd.exec  = 1'b1;
                n_out_valid = 1'b1;
                n_state     = seiq_pkg::CTL_IDLE;
            end
            default: begin
                n_state = seiq_pkg::CTL_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;

`ifndef SYNTH
    a_exec_follows_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> o_cmd.exec)
        else $error("Execute did not follow a load.");
    a_exec_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.exec |-> !r_out_valid)
        else $error("Execute while the output register is still full.");
    a_abort_blocks_nothing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_sts.aborted && i_sts.empty && r_state == seiq_pkg::CTL_EXEC) |=> r_out_valid)
        else $error("No result after an execute.");
`endif

endmodule

[rtl/seiq_dpath.sv]
// Datapath of the sorted event insertion queue.
// Holds the sorted entry cells, the count, the abort flag, capacity and the item registers.
// Depends on seiq_pkg.
module seiq_dpath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [seiq_pkg::CAP_W-1:0]    i_cfg_wdata,
    input  seiq_pkg::t_in_item            i_in,
    output seiq_pkg::t_out_item           o_out,
    input  seiq_pkg::t_dp_cmd             i_cmd,
    output seiq_pkg::t_dp_sts             o_sts
);

    logic [15:0]                   r_ser  [seiq_pkg::DEPTH];
    logic signed [47:0]            r_time [seiq_pkg::DEPTH];
    logic [15:0]                   r_pay  [seiq_pkg::DEPTH];
    logic [seiq_pkg::OCC_W-1:0]    r_occ;
    logic [seiq_pkg::OCC_W-1:0]    n_occ;
    logic                          r_abort;
    logic                          n_abort;
    logic [seiq_pkg::CAP_W-1:0]    r_cap;
    seiq_pkg::t_in_item            r_in;
    seiq_pkg::t_out_item           r_out;
    seiq_pkg::t_out_item           n_out;
    logic [seiq_pkg::DEPTH-1:0]    stay;
    logic                          full;
    logic                          do_push;
    logic                          do_pop;

    always_comb begin
        for (int i = 0; i < seiq_pkg::DEPTH; i++) begin
            stay[i] = (seiq_pkg::OCC_W'(i) < r_occ) &&
                      ((r_in.in_serial != r_ser[i]) ? (r_in.in_serial > r_ser[i])
                                                    : (r_in.in_time >= r_time[i]));
        end
    end

    assign full = (int'(r_occ) >= int'(r_cap)) || (int'(r_occ) >= seiq_pkg::DEPTH);

    always_comb begin
        n_occ   = r_occ;
        n_abort = r_abort;
        do_push = 1'b0;
        do_pop  = 1'b0;
        n_out   = '0;
        n_out.status = seiq_pkg::STAT_OK;
        unique case (r_in.func)
            seiq_pkg::FUNC_PUSH: begin
                if (r_abort) begin
                    n_out.status = seiq_pkg::STAT_ABORTED;
                end else if (full) begin
                    n_out.status = seiq_pkg::STAT_REFUSED;
                end else begin
                    do_push = 1'b1;
                    n_occ   = r_occ + seiq_pkg::OCC_W'(1);
                end
            end
            seiq_pkg::FUNC_POP: begin
                if (r_abort) begin
                    n_out.status = seiq_pkg::STAT_ABORTED;
                end else if (r_occ == '0) begin
                    n_out.status = seiq_pkg::STAT_REFUSED;
                end else begin
                    do_pop            = 1'b1;
                    n_occ             = r_occ - seiq_pkg::OCC_W'(1);
                    n_out.out_serial  = r_ser[0];
                    n_out.out_time    = r_time[0];
                    n_out.out_payload = r_pay[0];
                end
            end
            seiq_pkg::FUNC_FLUSH: begin
                n_occ = '0;
            end
            seiq_pkg::FUNC_ABORT: begin
                n_abort = 1'b1;
            end
            seiq_pkg::FUNC_RESET: begin
                n_occ   = '0;
                n_abort = 1'b0;
            end
            default: begin
            end
        endcase
        n_out.count = seiq_pkg::COUNT_W'(n_occ);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ   <= '0;
            r_abort <= 1'b0;
            r_cap   <= seiq_pkg::CAP_W'(16);
        end else begin
            if (i_cfg_we) begin
                r_cap <= i_cfg_wdata;
            end
            if (i_cmd.exec) begin
                r_occ   <= n_occ;
                r_abort <= n_abort;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_in <= i_in;
        end
        if (i_cmd.exec) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < seiq_pkg::DEPTH; i++) begin
            if (i_cmd.exec && do_push && !stay[i]) begin
                if (i == 0 || stay[(i == 0) ? 0 : i - 1]) begin
                    r_ser[i]  <= r_in.in_serial;
                    r_time[i] <= r_in.in_time;
                    r_pay[i]  <= r_in.in_payload;
                end else begin
                    r_ser[i]  <= r_ser[(i == 0) ? 0 : i - 1];
                    r_time[i] <= r_time[(i == 0) ? 0 : i - 1];
                    r_pay[i]  <= r_pay[(i == 0) ? 0 : i - 1];
                end
            end else if (i_cmd.exec && do_pop && i < seiq_pkg::DEPTH - 1) begin
                r_ser[i]  <= r_ser[(i < seiq_pkg::DEPTH - 1) ? i + 1 : i];
                r_time[i] <= r_time[(i < seiq_pkg::DEPTH - 1) ? i + 1 : i];
                r_pay[i]  <= r_pay[(i < seiq_pkg::DEPTH - 1) ? i + 1 : i];
            end
        end
    end

    assign o_out         = r_out;
    assign o_sts.aborted = r_abort;
    assign o_sts.empty   = (r_occ == '0);

`ifndef SYNTH
    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_occ) <= seiq_pkg::DEPTH)
        else $error("Entry count exceeds the depth.");
    a_refused_keeps_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.exec |=> (r_out.status == seiq_pkg::STAT_OK || r_occ == $past(r_occ)))
        else $error("A refused item changed the entry count.");
    a_reset_func: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.exec && r_in.func == seiq_pkg::FUNC_RESET) |=> (r_occ == '0 && !r_abort))
        else $error("Reset function left entries or the abort flag.");
`endif

endmodule

[rtl/sorted_event_insert_queue_top.sv]
// Top level of the sorted event insertion queue.
// Joins the controller and the datapath; depends on seiq_pkg, seiq_ctrl and seiq_dpath.
//
//   channel   valid          stall          payload
//   input     i_in_valid     o_in_stall     i_in  (seiq_pkg::t_in_item)
//   output    o_out_valid    i_out_stall    o_out (seiq_pkg::t_out_item)
//   config    i_cfg_we       (none)         i_cfg_wdata (capacity)
//
// Each item is registered in the idle state; the exec state then updates the cells and
// loads the output register. All cells compare against the new key in parallel.
// A new item is taken while a result is being taken, but not while it is stalled, nor in the exec state.
// Reset empties the queue, clears the abort flag and sets capacity to 16.
module sorted_event_insert_queue_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [seiq_pkg::CAP_W-1:0]    i_cfg_wdata,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  seiq_pkg::t_in_item            i_in,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output seiq_pkg::t_out_item           o_out
);

    seiq_pkg::t_dp_cmd cmd;
    seiq_pkg::t_dp_sts sts;

    seiq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    seiq_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (i_in),
        .o_out       (o_out),
        .i_cmd       (cmd),
        .o_sts       (sts)
    );

endmodule
